>>> src/pmd_pkg.sv
// Package for the partitioned multi-deque: sizes, request and status codes,
// and the structs passed between the control, store and output stages.
// Depends on nothing; every other file uses it by scoped names.
package pmd_pkg;

    // Geometry of the shared store.
    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int DATA_WIDTH  = 32;

    localparam int STORE_SIZE = NUM_QUEUES * QUEUE_DEPTH;
    localparam int QID_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    // Request codes as they arrive on req_type.
    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } req_kind_t;

    // Result codes as they leave on status.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Access to the slot store issued at the transfer of a request.
    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
    } mem_req_t;

    // Result fields settled in the first stage, waiting for the read data.
    typedef struct packed {
        logic    use_rdata;
        logic    rejected_pop;
        status_t status;
        logic    now_empty;
        logic    now_full;
    } stage_t;

endpackage

>>> src/pmd_store.sv
// Slot store of the partitioned multi-deque: one synchronous memory with a
// single write port and a registered read port.
// Depends on pmd_pkg for sizes and the access struct.
module pmd_store (
    input  logic                          clk,
    input  pmd_pkg::mem_req_t             mem_req,
    output logic [pmd_pkg::DATA_WIDTH-1:0] rd_data
);

    logic [pmd_pkg::DATA_WIDTH-1:0] mem [pmd_pkg::STORE_SIZE];
    logic [pmd_pkg::DATA_WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/pmd_ctrl.sv
// Request control of the partitioned multi-deque: per-deque head, tail and
// empty state, the store access for each request, and the first stage register.
// Depends on pmd_pkg.
module pmd_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [1:0]                     req_type,
    input  logic [1:0]                     queue_id,
    input  logic signed [31:0]             push_value,
    input  logic                           advance,
    output pmd_pkg::mem_req_t              mem_req,
    output logic                           stage_valid,
    output pmd_pkg::stage_t                stage_info
);

    logic [pmd_pkg::PTR_W-1:0] head_reg [pmd_pkg::NUM_QUEUES];
    logic [pmd_pkg::PTR_W-1:0] tail_reg [pmd_pkg::NUM_QUEUES];
    logic [pmd_pkg::NUM_QUEUES-1:0] vacant_reg;
    logic [pmd_pkg::PTR_W-1:0] head_next;
    logic [pmd_pkg::PTR_W-1:0] tail_next;
    logic                      vacant_next;

    logic                      stage_valid_reg;
    logic                      stage_valid_next;
    pmd_pkg::stage_t           stage_info_reg;
    pmd_pkg::stage_t           stage_info_next;

    logic                      accept;
    logic [pmd_pkg::QID_W-1:0] qsel;
    pmd_pkg::req_kind_t        kind;
    logic [pmd_pkg::PTR_W-1:0] head_cur;
    logic [pmd_pkg::PTR_W-1:0] tail_cur;
    logic                      vacant_cur;
    logic                      full_cur;
    logic [pmd_pkg::PTR_W-1:0] slot;

    // Pointer steps that wrap inside one region.
    function automatic logic [pmd_pkg::PTR_W-1:0] step_up(
        input logic [pmd_pkg::PTR_W-1:0] p
    );
        return (p == pmd_pkg::PTR_W'(pmd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [pmd_pkg::PTR_W-1:0] step_down(
        input logic [pmd_pkg::PTR_W-1:0] p
    );
        return (p == '0) ? pmd_pkg::PTR_W'(pmd_pkg::QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    // A new request may enter when the first stage is free or moving on.
    assign req_ready = !stage_valid_reg || advance;
    assign accept    = req_valid && req_ready;

    assign qsel       = pmd_pkg::QID_W'(queue_id % pmd_pkg::NUM_QUEUES);
    assign kind       = pmd_pkg::req_kind_t'(req_type);
    assign head_cur   = head_reg[qsel];
    assign tail_cur   = tail_reg[qsel];
    assign vacant_cur = vacant_reg[qsel];
    assign full_cur   = !vacant_cur && (step_up(tail_cur) == head_cur);

    // Decode the request against the addressed deque's pointers.
    always_comb
    begin
        head_next   = head_cur;
        tail_next   = tail_cur;
        vacant_next = vacant_cur;
        slot        = '0;
        stage_info_next.use_rdata    = 1'b0;
        stage_info_next.rejected_pop = 1'b0;
        stage_info_next.status       = pmd_pkg::ST_DONE;
        mem_req.wr_en = 1'b0;
        mem_req.rd_en = 1'b0;

        case (kind)
            pmd_pkg::REQ_PUSH_FRONT, pmd_pkg::REQ_PUSH_REAR:
            begin
                if (full_cur)
                begin
                    stage_info_next.status = pmd_pkg::ST_FULL;
                end
                else
                begin
                    mem_req.wr_en = accept;
                    if (vacant_cur)
                    begin
                        // First element lands at the start of the region.
                        head_next   = '0;
                        tail_next   = '0;
                        vacant_next = 1'b0;
                        slot        = '0;
                    end
                    else if (kind == pmd_pkg::REQ_PUSH_FRONT)
                    begin
                        head_next = step_down(head_cur);
                        slot      = head_next;
                    end
                    else
                    begin
                        tail_next = step_up(tail_cur);
                        slot      = tail_next;
                    end
                end
            end
            pmd_pkg::REQ_POP_FRONT, pmd_pkg::REQ_POP_REAR:
            begin
                if (vacant_cur)
                begin
                    stage_info_next.status       = pmd_pkg::ST_EMPTY;
                    stage_info_next.rejected_pop = 1'b1;
                end
                else
                begin
                    mem_req.rd_en             = accept;
                    stage_info_next.use_rdata = 1'b1;
                    slot = (kind == pmd_pkg::REQ_POP_FRONT) ? head_cur : tail_cur;
                    if (head_cur == tail_cur)
                    begin
                        // Last element leaves; both ends go back to the start.
                        vacant_next = 1'b1;
                        head_next   = '0;
                        tail_next   = '0;
                    end
                    else if (kind == pmd_pkg::REQ_POP_FRONT)
                    begin
                        head_next = step_up(head_cur);
                    end
                    else
                    begin
                        tail_next = step_down(tail_cur);
                    end
                end
            end
            default:
            begin
                stage_info_next.status = pmd_pkg::ST_DONE;
            end
        endcase

        stage_info_next.now_empty = vacant_next;
        stage_info_next.now_full  = !vacant_next && (step_up(tail_next) == head_next);

        // Store address of the slot within the addressed region.
        mem_req.wr_addr = pmd_pkg::ADDR_W'(int'(qsel) * pmd_pkg::QUEUE_DEPTH + int'(slot));
        mem_req.rd_addr = mem_req.wr_addr;
        mem_req.wr_data = pmd_pkg::DATA_WIDTH'(push_value);
    end

    // Per-deque pointer state, updated at each request transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pmd_pkg::NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            vacant_reg <= '1;
        end
        else if (accept)
        begin
            head_reg[qsel]   <= head_next;
            tail_reg[qsel]   <= tail_next;
            vacant_reg[qsel] <= vacant_next;
        end
    end

    // First stage: holds the settled fields while the read completes.
    assign stage_valid_next = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_info_reg <= stage_info_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_info  = stage_info_reg;

endmodule

>>> src/partitioned_multi_deque.sv
// Partitioned multi-deque, top level.
//
// Four circular deques share one slot store; each owns an equal region and
// its head and tail wrap inside that region. A request arrives on the req
// channel (req_valid, req_ready, req_type, queue_id, push_value) and produces
// exactly one response on the rsp channel (rsp_valid, rsp_ready, pop_value,
// status, now_empty, now_full). A transfer happens on each channel when its
// valid and ready are both high.
// rsp_valid rises when the response register loads: the slot store read and
// the first stage are registered at the transfer, and the response register
// loads from them once it is free. Throughput is one request per cycle while
// rsp_ready stays high; pointer updates take effect at the transfer, so back-to-back
// requests to the same deque see each other, and a pop right after a push reads the written slot.
// A rejected push returns status full, a rejected pop returns status empty
// with pop_value of -1; neither changes any state.
// When the receiver stalls, the response register and the first stage fill
// and then req_ready drops; nothing is lost. Reset empties every deque and
// returns all pointers to the start of their regions; the slot store itself
// is not cleared, and no reset pass is needed.
// Depends on pmd_pkg, pmd_ctrl and pmd_store.
module partitioned_multi_deque (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         req_type,
    input  logic [1:0]         queue_id,
    input  logic signed [31:0] push_value,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic signed [31:0] pop_value,
    output logic [1:0]         status,
    output logic               now_empty,
    output logic               now_full
);

    pmd_pkg::mem_req_t              mem_req;
    logic [pmd_pkg::DATA_WIDTH-1:0] rd_data;
    logic                           stage_valid;
    pmd_pkg::stage_t                stage_info;
    logic                           advance;

    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    logic signed [31:0]             pop_value_reg;
    logic signed [31:0]             pop_value_next;
    pmd_pkg::status_t               status_reg;
    logic                           now_empty_reg;
    logic                           now_full_reg;

    pmd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .queue_id    (queue_id),
        .push_value  (push_value),
        .advance     (advance),
        .mem_req     (mem_req),
        .stage_valid (stage_valid),
        .stage_info  (stage_info)
    );

    pmd_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // The response register takes a new result when it is empty or being taken.
    assign advance = !rsp_valid_reg || rsp_ready;

    // Popped data is sign-extended from the stored width.
    always_comb
    begin
        if (stage_info.use_rdata)
        begin
            pop_value_next = 32'($signed(rd_data));
        end
        else if (stage_info.rejected_pop)
        begin
            pop_value_next = -32'sd1;
        end
        else
        begin
            pop_value_next = '0;
        end
    end

    assign rsp_valid_next = (advance) ? stage_valid : rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            pop_value_reg <= pop_value_next;
            status_reg    <= stage_info.status;
            now_empty_reg <= stage_info.now_empty;
            now_full_reg  <= stage_info.now_full;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign now_empty = now_empty_reg;
    assign now_full  = now_full_reg;

    // A rejected pop reports an empty deque and the value -1.
    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == pmd_pkg::ST_EMPTY) |-> (now_empty && pop_value == -32'sd1))
        else $error("rejected pop without empty flag or -1 value");

    // A rejected push reports a full deque.
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == pmd_pkg::ST_FULL) |-> (now_full && !now_empty))
        else $error("rejected push without full flag");

    // A deque is never empty and full at once.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(now_empty && now_full))
        else $error("empty and full flags both set");

    // A held first stage blocks new requests.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !advance) |-> !req_ready)
        else $error("request taken while first stage is stalled");

endmodule

>>> bench/partitioned_multi_deque_tb.sv
// Self-checking testbench for partitioned_multi_deque: directed and random
// deque requests, with a model of all four deques predicting each reply.
// Depends on pmd_pkg and the partitioned_multi_deque top level.
module partitioned_multi_deque_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected fields of one reply.
    typedef struct {
        logic signed [31:0] pop_value;
        pmd_pkg::status_t   status;
        logic               now_empty;
        logic               now_full;
    } deque_reply_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [1:0]         req_type;
    logic [1:0]         queue_id;
    logic signed [31:0] push_value;
    logic               rsp_valid;
    logic               rsp_ready;
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic               now_empty;
    logic               now_full;

    // Shadow state of the deques.
    logic [pmd_pkg::DATA_WIDTH-1:0] shadow_slots [pmd_pkg::STORE_SIZE];
    int                    front_ptr [pmd_pkg::NUM_QUEUES];
    int                    rear_ptr  [pmd_pkg::NUM_QUEUES];
    bit                    vacant    [pmd_pkg::NUM_QUEUES];
    bit                    draining  [pmd_pkg::NUM_QUEUES];

    // Replies predicted at request transfer, oldest first.
    deque_reply_t replies_due [$];

    // Pacing controls shared by the sender, the receiver and the tests.
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    int rx_hold_cycles = 0;

    // Run statistics.
    int mismatch_count = 0;
    int replies_checked = 0;
    int pushes_done = 0;
    int pops_done = 0;
    int full_rejects = 0;
    int empty_rejects = 0;

    partitioned_multi_deque dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .queue_id   (queue_id),
        .push_value (push_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .pop_value  (pop_value),
        .status     (status),
        .now_empty  (now_empty),
        .now_full   (now_full)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length: mostly none or short, occasionally long.
    function automatic int pick_gap(bit eager);
        int r;
        r = $urandom_range(0, 99);
        if (eager)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Data word with the sign and range extremes mixed in.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int ptr_inc(int p);
        return (p + 1 >= pmd_pkg::QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int ptr_dec(int p);
        return (p == 0) ? pmd_pkg::QUEUE_DEPTH - 1 : p - 1;
    endfunction

    function automatic bit deque_is_full(int q);
        return !vacant[q] && ptr_inc(rear_ptr[q]) == front_ptr[q];
    endfunction

    // Applies one request to the shadow deques and returns the reply it earns.
    function automatic deque_reply_t apply_request(pmd_pkg::req_kind_t kind, logic [1:0] qid,
                                                   logic [31:0] value);
        deque_reply_t                          r;
        int                                    q;
        int                                    base;
        int                                    p;
        logic signed [63:0]                    wide;
        logic signed [pmd_pkg::DATA_WIDTH-1:0] word;
        q = qid % pmd_pkg::NUM_QUEUES;
        base = q * pmd_pkg::QUEUE_DEPTH;
        r.pop_value = '0;
        r.status = pmd_pkg::ST_DONE;
        if (kind == pmd_pkg::REQ_PUSH_FRONT || kind == pmd_pkg::REQ_PUSH_REAR)
        begin
            if (deque_is_full(q))
                r.status = pmd_pkg::ST_FULL;
            else
            begin
                // The first push into an empty deque lands at the region start.
                if (vacant[q])
                begin
                    front_ptr[q] = 0;
                    rear_ptr[q] = 0;
                    vacant[q] = 1'b0;
                    p = 0;
                end
                else if (kind == pmd_pkg::REQ_PUSH_FRONT)
                begin
                    front_ptr[q] = ptr_dec(front_ptr[q]);
                    p = front_ptr[q];
                end
                else
                begin
                    rear_ptr[q] = ptr_inc(rear_ptr[q]);
                    p = rear_ptr[q];
                end
                wide = $signed(value);
                shadow_slots[base + p] = wide[pmd_pkg::DATA_WIDTH-1:0];
            end
        end
        else
        begin
            if (vacant[q])
            begin
                r.status = pmd_pkg::ST_EMPTY;
                r.pop_value = -32'sd1;
            end
            else
            begin
                p = (kind == pmd_pkg::REQ_POP_FRONT) ? front_ptr[q] : rear_ptr[q];
                word = shadow_slots[base + p];
                wide = word;
                r.pop_value = wide[31:0];
                // Popping the last element empties the deque and rewinds it.
                if (front_ptr[q] == rear_ptr[q])
                begin
                    vacant[q] = 1'b1;
                    front_ptr[q] = 0;
                    rear_ptr[q] = 0;
                end
                else if (kind == pmd_pkg::REQ_POP_FRONT)
                    front_ptr[q] = ptr_inc(front_ptr[q]);
                else
                    rear_ptr[q] = ptr_dec(rear_ptr[q]);
            end
        end
        r.now_empty = vacant[q];
        r.now_full = deque_is_full(q);
        return r;
    endfunction

    // Offers one request, holding valid across back-to-back transfers.
    task automatic offer_request(pmd_pkg::req_kind_t kind, logic [1:0] qid,
                                 logic [31:0] value);
        int           gap;
        deque_reply_t r;
        gap = pick_gap(tx_eager);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= kind;
        queue_id   <= qid;
        push_value <= value;
        do
            @(posedge clk);
        while (!req_ready);
        r = apply_request(kind, qid, value);
        replies_due.push_back(r);
        case (r.status)
            pmd_pkg::ST_FULL:  full_rejects++;
            pmd_pkg::ST_EMPTY: empty_rejects++;
            default:
            begin
                if (kind == pmd_pkg::REQ_PUSH_FRONT || kind == pmd_pkg::REQ_PUSH_REAR)
                    pushes_done++;
                else
                    pops_done++;
            end
        endcase
    endtask

    // Pops on deques that were never written are rejected.
    task automatic test_empty_pops();
        offer_request(pmd_pkg::REQ_POP_FRONT, 2'd0, 32'h1234_5678);
        offer_request(pmd_pkg::REQ_POP_REAR, 2'd2, 32'hFFFF_FFFF);
    endtask

    // Extreme values survive a round trip through both ends.
    task automatic test_value_extremes();
        offer_request(pmd_pkg::REQ_PUSH_FRONT, 2'd3, 32'h7FFF_FFFF);
        offer_request(pmd_pkg::REQ_PUSH_REAR, 2'd3, 32'h8000_0000);
        offer_request(pmd_pkg::REQ_POP_REAR, 2'd3, 32'h0);
        offer_request(pmd_pkg::REQ_POP_FRONT, 2'd3, 32'h0);
    endtask

    // Fill one deque across the region wrap, push into it while full, then pop from both ends.
    task automatic test_fill_and_overflow();
        int i;
        for (i = 0; i < pmd_pkg::QUEUE_DEPTH / 2; i++)
            offer_request(pmd_pkg::REQ_PUSH_FRONT, 2'd1, pick_word());
        for (i = pmd_pkg::QUEUE_DEPTH / 2; i < pmd_pkg::QUEUE_DEPTH; i++)
            offer_request(pmd_pkg::REQ_PUSH_REAR, 2'd1, pick_word());
        offer_request(pmd_pkg::REQ_PUSH_REAR, 2'd1, 32'hDEAD_BEEF);
        offer_request(pmd_pkg::REQ_PUSH_FRONT, 2'd1, 32'hCAFE_F00D);
        offer_request(pmd_pkg::REQ_POP_FRONT, 2'd1, 32'h0);
        offer_request(pmd_pkg::REQ_POP_REAR, 2'd1, 32'h0);
    endtask

    // Mostly fill-then-drain runs per deque, with some fully random requests.
    task automatic test_random_traffic(int count);
        int                 i;
        int                 q;
        pmd_pkg::req_kind_t kind;
        for (i = 0; i < count; i++)
        begin
            q = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
                kind = pmd_pkg::req_kind_t'($urandom_range(0, 3));
            else if (draining[q % pmd_pkg::NUM_QUEUES] == ($urandom_range(0, 4) != 0))
                kind = $urandom_range(0, 1) ? pmd_pkg::REQ_POP_FRONT : pmd_pkg::REQ_POP_REAR;
            else
                kind = $urandom_range(0, 1) ? pmd_pkg::REQ_PUSH_FRONT : pmd_pkg::REQ_PUSH_REAR;
            offer_request(kind, q[1:0], pick_word());
            if (vacant[q % pmd_pkg::NUM_QUEUES])
                draining[q % pmd_pkg::NUM_QUEUES] = 1'b0;
            else if (deque_is_full(q % pmd_pkg::NUM_QUEUES))
                draining[q % pmd_pkg::NUM_QUEUES] = 1'b1;
        end
    endtask

    // Back-to-back traffic on both sides with no idling.
    task automatic test_streaming(int count);
        tx_eager = 1'b1;
        rx_eager = 1'b1;
        test_random_traffic(count);
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills up.
    task automatic test_backpressure(int count);
        req_valid <= 1'b0;
        rx_hold_cycles = 200;
        while (rx_hold_cycles != 0)
            @(posedge clk);
        tx_eager = 1'b1;
        test_random_traffic(count);
        tx_eager = 1'b0;
    endtask

    // Receiver side: random ready pattern, plus the long hold-off on request.
    initial
    begin : reply_pacer
        int n;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
                rsp_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                n = pick_gap(rx_eager);
                if (n > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // Compare each reply transfer with the oldest prediction.
    always @(posedge clk)
    begin : reply_checker
        deque_reply_t want;
        if (rst_n === 1'b1 && rsp_valid && rsp_ready)
        begin
            if (replies_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: reply with nothing pending: pop=%0d status=%0d e=%0b f=%0b",
                             $realtime, pop_value, status, now_empty, now_full);
            end
            else
            begin
                want = replies_due.pop_front();
                replies_checked++;
                if (pop_value !== want.pop_value || status !== want.status ||
                    now_empty !== want.now_empty || now_full !== want.now_full)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch: expected pop=%0d status=%0d e=%0b f=%0b,",
                                  " got pop=%0d status=%0d e=%0b f=%0b"},
                                 $realtime, want.pop_value, want.status, want.now_empty,
                                 want.now_full, pop_value, status, now_empty, now_full);
                end
            end
        end
    end

    // Stimulus sequence and final verdict.
    initial
    begin : run_tests
        int i;
        for (i = 0; i < pmd_pkg::NUM_QUEUES; i++)
        begin
            front_ptr[i] = 0;
            rear_ptr[i] = 0;
            vacant[i] = 1'b1;
            draining[i] = 1'b0;
        end
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req_type   <= pmd_pkg::REQ_PUSH_FRONT;
        queue_id   <= '0;
        push_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pops();
        test_value_extremes();
        test_fill_and_overflow();
        test_backpressure(30);
        test_streaming(40);
        test_random_traffic(420);

        // Drain the replies still in flight.
        req_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d replies: %0d pushes, %0d pops, %0d full and %0d empty rejects.",
                 replies_checked, pushes_done, pops_done, full_rejects, empty_rejects);
        $display("Traffic included idle gaps, a no-idle stretch and a long receiver stall.");
        if (mismatch_count > 0)
        begin
            $display("%0d mismatches in total.", mismatch_count);
            $display("Test completed with failures");
        end
        else
            $display("Test completed successfully");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #4_000_000;
        $display("Timeout with %0d replies outstanding.", replies_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
src/pmd_pkg.sv
src/pmd_store.sv
src/pmd_ctrl.sv
src/partitioned_multi_deque.sv
bench/partitioned_multi_deque_tb.sv
